// ===== hw/rtl/fcbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_pkg
// shared types, constants and the gap bucket function of the cadence estimator
// ----------------------------------------------------------------------------
package fcbe_pkg;

    localparam int DEFAULT_HISTORY_DEPTH = 8;

    localparam int CMD_W  = 2;
    localparam int TIME_W = 64;
    localparam int BYTE_W = 32;
    localparam int FPS_W  = 9;
    localparam int KBPS_W = 36;
    localparam int HELD_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FR_NUM       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FR_DEN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_CTRL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BITRATE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_PERF    = 3'd5;

    localparam logic [TIME_W-1:0] GAP_MIN     = 64'd2000000;
    localparam logic [TIME_W-1:0] GAP_FPS_24  = 64'd40000000;
    localparam logic [TIME_W-1:0] GAP_FPS_30  = 64'd25000000;
    localparam logic [TIME_W-1:0] GAP_FPS_60  = 64'd12500000;
    localparam logic [TIME_W-1:0] GAP_FPS_120 = 64'd6940000;
    localparam logic [TIME_W-1:0] GAP_FPS_180 = 64'd4860000;
    localparam logic [TIME_W-1:0] GAP_FPS_240 = 64'd3125000;

    localparam logic [FPS_W-1:0] FPS_MAX     = 9'd480;
    localparam logic [FPS_W-1:0] FPS_DEFAULT = 9'd60;

    typedef struct packed {
        logic                  encoder_mode;
        logic [BYTE_W-1:0]     fr_num;
        logic [BYTE_W-1:0]     fr_den;
        logic                  rate_ctrl;
        logic [BYTE_W-1:0]     bitrate;
        logic                  high_perf;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_APPLY,
        OP_SCAN_INIT,
        OP_READ_A,
        OP_LATCH_A,
        OP_READ_B,
        OP_DIFF_B,
        OP_UPD_B,
        OP_NEXT_A,
        OP_PREP,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic encoder_mode;
        logic a_done;
        logic b_done;
        logic div_done;
    } stat_t;

    function automatic logic [FPS_W-1:0] gap_to_fps(input logic [TIME_W-1:0] g,
                                                    input logic found);
        logic [FPS_W-1:0] f;
        if (!found || g < GAP_MIN)  f = FPS_DEFAULT;
        else if (g > GAP_FPS_24)    f = 9'd24;
        else if (g > GAP_FPS_30)    f = 9'd30;
        else if (g > GAP_FPS_60)    f = 9'd60;
        else if (g > GAP_FPS_120)   f = 9'd120;
        else if (g > GAP_FPS_180)   f = 9'd180;
        else if (g > GAP_FPS_240)   f = 9'd240;
        else                        f = FPS_MAX;
        return f;
    endfunction

endpackage

// ===== hw/rtl/fcbe_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_in_if / fcbe_out_if
// valid/ready channels carrying buffer words and estimate words
// ----------------------------------------------------------------------------
interface fcbe_in_if;
    logic                              valid;
    logic                              ready;
    logic [fcbe_pkg::CMD_W-1:0]        command;
    logic [fcbe_pkg::TIME_W-1:0]       frame_time;
    logic [fcbe_pkg::BYTE_W-1:0]       payload_bytes;
    modport source (output valid, command, frame_time, payload_bytes, input ready);
    modport sink   (input valid, command, frame_time, payload_bytes, output ready);
endinterface

interface fcbe_out_if;
    logic                              valid;
    logic                              ready;
    logic [fcbe_pkg::FPS_W-1:0]        frames_per_second;
    logic [fcbe_pkg::KBPS_W-1:0]       kilobit_rate;
    logic [fcbe_pkg::HELD_W-1:0]       samples_held;
    modport source (output valid, frames_per_second, kilobit_rate, samples_held,
                    input ready);
    modport sink   (input valid, frames_per_second, kilobit_rate, samples_held,
                    output ready);
endinterface

// ===== hw/rtl/fcbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module fcbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/fcbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_ctrl
// sequencer: history update, pairwise gap scan, division and result hand-off
// ----------------------------------------------------------------------------
module fcbe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fcbe_pkg::ctrl_t   ctrl,
    input  fcbe_pkg::stat_t   stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_APPLY, S_SCAN_INIT, S_READ_A, S_LATCH_A, S_READ_B,
        S_DIFF_B, S_UPD_B, S_PREP, S_DIV_START, S_DIV_RUN, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.op        = fcbe_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.op    = fcbe_pkg::OP_CAPTURE;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                ctrl.op    = fcbe_pkg::OP_APPLY;
                state_next = stat.encoder_mode ? S_DIV_START : S_SCAN_INIT;
            end
            S_SCAN_INIT:
            begin
                ctrl.op    = fcbe_pkg::OP_SCAN_INIT;
                state_next = S_READ_A;
            end
            S_READ_A:
            begin
                if (stat.a_done)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    ctrl.op    = fcbe_pkg::OP_READ_A;
                    state_next = S_LATCH_A;
                end
            end
            S_LATCH_A:
            begin
                ctrl.op    = fcbe_pkg::OP_LATCH_A;
                state_next = S_READ_B;
            end
            S_READ_B:
            begin
                if (stat.b_done)
                begin
                    ctrl.op    = fcbe_pkg::OP_NEXT_A;
                    state_next = S_READ_A;
                end
                else
                begin
                    ctrl.op    = fcbe_pkg::OP_READ_B;
                    state_next = S_DIFF_B;
                end
            end
            S_DIFF_B:
            begin
                ctrl.op    = fcbe_pkg::OP_DIFF_B;
                state_next = S_UPD_B;
            end
            S_UPD_B:
            begin
                ctrl.op    = fcbe_pkg::OP_UPD_B;
                state_next = S_READ_B;
            end
            S_PREP:
            begin
                ctrl.op    = fcbe_pkg::OP_PREP;
                state_next = S_DIV_START;
            end
            S_DIV_START:
            begin
                ctrl.op    = fcbe_pkg::OP_DIV_START;
                state_next = S_DIV_RUN;
            end
            S_DIV_RUN:
            begin
                ctrl.op = fcbe_pkg::OP_DIV_STEP;
                if (stat.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.op        = fcbe_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ===== hw/rtl/fcbe_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_datapath
// sample history, gap search, running sum, shared divider and result registers
// ----------------------------------------------------------------------------
module fcbe_datapath #(
    parameter int HISTORY_DEPTH = fcbe_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fcbe_pkg::ctrl_t               ctrl,
    output fcbe_pkg::stat_t               stat,
    input  fcbe_pkg::cfg_t                cfg,
    input  logic [fcbe_pkg::CMD_W-1:0]    in_command,
    input  logic [fcbe_pkg::TIME_W-1:0]   in_time,
    input  logic [fcbe_pkg::BYTE_W-1:0]   in_bytes,
    output logic [fcbe_pkg::FPS_W-1:0]    fps_out,
    output logic [fcbe_pkg::KBPS_W-1:0]   kbps_out,
    output logic [fcbe_pkg::HELD_W-1:0]   held_out
);
    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = fcbe_pkg::BYTE_W + CNT_W;
    localparam int PROD_W = SUM_W + fcbe_pkg::FPS_W;
    localparam int TW     = fcbe_pkg::TIME_W;
    localparam int BW     = fcbe_pkg::BYTE_W;

    logic [fcbe_pkg::CMD_W-1:0] cmd_reg;
    logic [TW-1:0]              time_reg;
    logic [BW-1:0]              bytes_reg;

    logic [IDX_W-1:0] slot_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] a_reg;
    logic [CNT_W-1:0] b_reg;
    logic [TW-1:0]    x_reg;
    logic [TW-1:0]    d_reg;
    logic [TW-1:0]    best_reg;
    logic             found_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [fcbe_pkg::FPS_W-1:0] fps_reg;

    logic [TW-1:0]              quo_reg;
    logic [BW-1:0]              rem_reg;
    logic [BW-1:0]              dsr_reg;
    logic [fcbe_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [TW-1:0]    t_rdata;
    logic [BW-1:0]    s_rdata;
    logic [IDX_W-1:0] raddr;
    logic             we;

    // divider step
    logic [BW:0]   rem_shift;
    logic          q_bit;
    logic [BW-1:0] rem_new;

    // result shaping
    logic [BW-1:0]    den_eff;
    logic [PROD_W-1:0] prod;
    logic [fcbe_pkg::FPS_W-1:0]  fps_fin;
    logic [fcbe_pkg::KBPS_W-1:0] kbps_base;
    logic [fcbe_pkg::KBPS_W:0]   kbps_tri;
    logic [CNT_W+fcbe_pkg::HELD_W-1:0] held_wide;

    assign we    = (ctrl.op == fcbe_pkg::OP_APPLY) && (cmd_reg == fcbe_pkg::CMD_RECORD)
                   && !cfg.encoder_mode && (bytes_reg != '0);
    assign raddr = (ctrl.op == fcbe_pkg::OP_READ_B) ? b_reg[IDX_W-1:0] : a_reg[IDX_W-1:0];

    fcbe_ram #(.WIDTH(TW), .DEPTH(HISTORY_DEPTH)) u_time_ram (
        .clk(clk), .we(we), .waddr(slot_reg), .wdata(time_reg),
        .raddr(raddr), .rdata(t_rdata)
    );

    fcbe_ram #(.WIDTH(BW), .DEPTH(HISTORY_DEPTH)) u_size_ram (
        .clk(clk), .we(we), .waddr(slot_reg), .wdata(bytes_reg),
        .raddr(raddr), .rdata(s_rdata)
    );

    assign stat.encoder_mode = cfg.encoder_mode;
    assign stat.a_done       = (a_reg == count_reg);
    assign stat.b_done       = (b_reg == a_reg);
    assign stat.div_done     = (div_cnt_reg == fcbe_pkg::DIV_CNT_W'(fcbe_pkg::DIV_STEPS - 1));

    assign rem_shift = {rem_reg, quo_reg[TW-1]};
    assign q_bit     = (rem_shift >= {1'b0, dsr_reg});
    assign rem_new   = q_bit ? BW'(rem_shift - {1'b0, dsr_reg}) : rem_shift[BW-1:0];

    assign den_eff = (cfg.fr_den == '0) ? BW'(1) : cfg.fr_den;
    assign prod    = PROD_W'(sum_reg) * PROD_W'(fps_reg);

    always_comb
    begin
        if (cfg.encoder_mode)
        begin
            if (quo_reg == '0)
            begin
                fps_fin = 9'd1;
            end
            else if (quo_reg > TW'(fcbe_pkg::FPS_MAX))
            begin
                fps_fin = fcbe_pkg::FPS_MAX;
            end
            else
            begin
                fps_fin = quo_reg[fcbe_pkg::FPS_W-1:0];
            end
            kbps_base = cfg.rate_ctrl ? fcbe_pkg::KBPS_W'(cfg.bitrate[BW-1:10]) : '0;
        end
        else
        begin
            fps_fin   = fps_reg;
            kbps_base = quo_reg[fcbe_pkg::KBPS_W-1:0];
        end
    end

    assign kbps_tri  = {kbps_base, 1'b0} + {1'b0, kbps_base};
    assign held_wide = {{fcbe_pkg::HELD_W{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            count_reg <= '0;
        end
        else if (ctrl.op == fcbe_pkg::OP_APPLY)
        begin
            if (we)
            begin
                slot_reg <= (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                if (count_reg < CNT_W'(HISTORY_DEPTH))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            else if (cmd_reg == fcbe_pkg::CMD_CLEAR)
            begin
                slot_reg  <= '0;
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            fcbe_pkg::OP_CAPTURE:
            begin
                cmd_reg   <= in_command;
                time_reg  <= in_time;
                bytes_reg <= in_bytes;
            end
            fcbe_pkg::OP_SCAN_INIT:
            begin
                a_reg     <= '0;
                sum_reg   <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
            end
            fcbe_pkg::OP_LATCH_A:
            begin
                x_reg   <= t_rdata;
                sum_reg <= sum_reg + SUM_W'(s_rdata);
                b_reg   <= '0;
            end
            fcbe_pkg::OP_DIFF_B:
            begin
                d_reg <= (x_reg > t_rdata) ? x_reg - t_rdata : t_rdata - x_reg;
            end
            fcbe_pkg::OP_UPD_B:
            begin
                if ((d_reg != '0) && (!found_reg || d_reg < best_reg))
                begin
                    best_reg  <= d_reg;
                    found_reg <= 1'b1;
                end
                b_reg <= b_reg + 1'b1;
            end
            fcbe_pkg::OP_NEXT_A:
            begin
                a_reg <= a_reg + 1'b1;
            end
            fcbe_pkg::OP_PREP:
            begin
                fps_reg <= fcbe_pkg::gap_to_fps(best_reg, found_reg);
            end
            fcbe_pkg::OP_DIV_START:
            begin
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                if (cfg.encoder_mode)
                begin
                    quo_reg <= TW'({1'b0, cfg.fr_num} + {1'b0, den_eff} - 1'b1);
                    dsr_reg <= den_eff;
                end
                else
                begin
                    // sum * 8 * fps / 1024 = sum * fps / 128, then divide by count
                    quo_reg <= TW'(prod[PROD_W-1:7]);
                    dsr_reg <= (count_reg == '0) ? BW'(1) : BW'(count_reg);
                end
            end
            fcbe_pkg::OP_DIV_STEP:
            begin
                rem_reg     <= rem_new;
                quo_reg     <= {quo_reg[TW-2:0], q_bit};
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            fcbe_pkg::OP_FINISH:
            begin
                fps_out  <= fps_fin;
                kbps_out <= cfg.high_perf ? kbps_base : kbps_tri[fcbe_pkg::KBPS_W-1:0];
                held_out <= held_wide[fcbe_pkg::HELD_W-1:0];
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== hw/rtl/frame_cadence_bitrate_estimator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_cadence_bitrate_estimator_unit
// per-stream frame rate and kilobit rate estimator for a video codec
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one buffer word per handshake: command, frame_time and
//   payload_bytes. every accepted word yields exactly one estimate word on
//   out_ch: frames_per_second, kilobit_rate and samples_held.
//   registers are written through cfg_we / cfg_index / cfg_data while idle.
// timing
//   decoder: the time per word grows with N = samples held; it is set by the
//   pairwise gap scan, which reads one stored timestamp per ram read, and the
//   64-step divider.
//   encoder: set by the divider alone.
//   one word is in flight at a time; in_ch.ready is high only when idle.
// reset
//   history becomes empty, registers take their reset values, no word pending.
// stall
//   the estimate sits in an output register; a new word may be accepted while
//   it waits, and the next estimate is held back until out_ch takes the old one.
// ----------------------------------------------------------------------------
module frame_cadence_bitrate_estimator_unit #(
    parameter int HISTORY_DEPTH = fcbe_pkg::DEFAULT_HISTORY_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fcbe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcbe_pkg::CFG_DATA_W-1:0]   cfg_data,
    fcbe_in_if.sink                           in_ch,
    fcbe_out_if.source                        out_ch
);
    fcbe_pkg::cfg_t  cfg_reg;
    fcbe_pkg::ctrl_t ctrl;
    fcbe_pkg::stat_t stat;

    // configuration registers; user must write only between words, not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.encoder_mode <= 1'b0;
            cfg_reg.fr_num       <= '0;
            cfg_reg.fr_den       <= fcbe_pkg::BYTE_W'(1);
            cfg_reg.rate_ctrl    <= 1'b0;
            cfg_reg.bitrate      <= '0;
            cfg_reg.high_perf    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcbe_pkg::CFG_ENCODER_MODE: cfg_reg.encoder_mode <= cfg_data[0];
                fcbe_pkg::CFG_FR_NUM:       cfg_reg.fr_num       <= cfg_data;
                fcbe_pkg::CFG_FR_DEN:       cfg_reg.fr_den       <= cfg_data;
                fcbe_pkg::CFG_RATE_CTRL:    cfg_reg.rate_ctrl    <= cfg_data[0];
                fcbe_pkg::CFG_BITRATE:      cfg_reg.bitrate      <= cfg_data;
                fcbe_pkg::CFG_HIGH_PERF:    cfg_reg.high_perf    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    fcbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    // history, gap search and divider
    fcbe_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .cfg        (cfg_reg),
        .in_command (in_ch.command),
        .in_time    (in_ch.frame_time),
        .in_bytes   (in_ch.payload_bytes),
        .fps_out    (out_ch.frames_per_second),
        .kbps_out   (out_ch.kilobit_rate),
        .held_out   (out_ch.samples_held)
    );

    // one word in flight: an accepted word drops ready for the next cycle
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("input accepted while a word is in flight");

    // frame rate estimates stay between 1 and FPS_MAX
    a_fps_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.frames_per_second != '0 &&
                          out_ch.frames_per_second <= fcbe_pkg::FPS_MAX))
        else $error("frame rate out of range");

    // encoder without rate control reports no bitrate
    a_enc_no_rc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && cfg_reg.encoder_mode && !cfg_reg.rate_ctrl)
            |-> (out_ch.kilobit_rate == '0))
        else $error("encoder kilobit rate nonzero with rate control off");

endmodule

// ===== dv/fcbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcbe_checker
// watches the buffer and estimate channels of the cadence estimator, predicts
// each estimate word from its own copy of history and registers, compares
// ----------------------------------------------------------------------------
module fcbe_checker
    import fcbe_pkg::*;
#(
    parameter int DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    fcbe_in_if.sink               in_mon,
    fcbe_out_if.sink              out_mon,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [FPS_W-1:0]  fps;
        logic [KBPS_W-1:0] kbps;
        logic [HELD_W-1:0] held;
    } estimate_t;

    estimate_t   estimate_q[$];
    logic [63:0] ts_ring[DEPTH];
    logic [31:0] sz_ring[DEPTH];
    int          slot;
    int          held;
    cfg_t        regs;

    assign pending = estimate_q.size();

    function automatic logic [8:0] bucket(input logic [63:0] g, input bit found);
        if (!found || g < 64'd2000000) return 9'd60;
        if (g > 64'd40000000) return 9'd24;
        if (g > 64'd25000000) return 9'd30;
        if (g > 64'd12500000) return 9'd60;
        if (g > 64'd6940000) return 9'd120;
        if (g > 64'd4860000) return 9'd180;
        if (g > 64'd3125000) return 9'd240;
        return 9'd480;
    endfunction

    // apply one buffer word to the model history and build the estimate
    function automatic estimate_t cadence_estimate(input logic [1:0] cmd,
                                                   input logic [63:0] ts,
                                                   input logic [31:0] bytes);
        estimate_t   e;
        logic [63:0] best, d, den, q, sum;
        logic [95:0] k;
        bit          found;
        best = 0;
        found = 0;
        sum = 0;
        if (cmd == CMD_RECORD) begin
            if (!regs.encoder_mode && bytes != 0) begin
                ts_ring[slot] = ts;
                sz_ring[slot] = bytes;
                slot = (slot + 1) % DEPTH;
                if (held < DEPTH) held++;
            end
        end else if (cmd == CMD_CLEAR) begin
            held = 0;
            slot = 0;
        end
        if (regs.encoder_mode) begin
            den = (regs.fr_den != 0) ? {32'd0, regs.fr_den} : 64'd1;
            q = ({32'd0, regs.fr_num} + den - 1) / den;
            if (q < 1) q = 1;
            if (q > 480) q = 480;
            e.fps = q[8:0];
            k = regs.rate_ctrl ? {64'd0, regs.bitrate} / 1024 : 96'd0;
        end else begin
            for (int a = 0; a < held; a++)
                for (int b = 0; b < a; b++) begin
                    d = (ts_ring[a] > ts_ring[b]) ? ts_ring[a] - ts_ring[b]
                                                  : ts_ring[b] - ts_ring[a];
                    if (d != 0 && (!found || d < best)) begin
                        best = d;
                        found = 1;
                    end
                end
            e.fps = bucket(best, found);
            for (int i = 0; i < held; i++) sum += sz_ring[i];
            k = ({32'd0, sum} * 8 * e.fps) / ((held ? held : 1) * 1024);
        end
        if (!regs.high_perf) k = k * 3;
        e.kbps = k[KBPS_W-1:0];
        e.held = held[HELD_W-1:0];
        return e;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        estimate_t got, want;
        if (!rst_n) begin
            estimate_q.delete();
            slot = 0;
            held = 0;
            errors = 0;
            regs = '{encoder_mode: 1'b0, fr_num: 32'd0, fr_den: 32'd1,
                     rate_ctrl: 1'b0, bitrate: 32'd0, high_perf: 1'b0};
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ENCODER_MODE: regs.encoder_mode = cfg_data[0];
                    CFG_FR_NUM:       regs.fr_num = cfg_data;
                    CFG_FR_DEN:       regs.fr_den = cfg_data;
                    CFG_RATE_CTRL:    regs.rate_ctrl = cfg_data[0];
                    CFG_BITRATE:      regs.bitrate = cfg_data;
                    CFG_HIGH_PERF:    regs.high_perf = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) begin
                got = '{out_mon.frames_per_second, out_mon.kilobit_rate,
                        out_mon.samples_held};
                if (estimate_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected estimate word fps=%0d kbps=%0d held=%0d",
                                 got.fps, got.kbps, got.held);
                end else begin
                    want = estimate_q.pop_front();
                    if (got != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch fps %0d/%0d kbps %0d/%0d held %0d/%0d",
                                     want.fps, got.fps, want.kbps, got.kbps,
                                     want.held, got.held);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                estimate_q.push_back(cadence_estimate(in_mon.command,
                                     in_mon.frame_time, in_mon.payload_bytes));
        end
    end

endmodule

// ===== dv/tb_frame_cadence_bitrate_estimator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_cadence_bitrate_estimator_unit
// drives buffer words and register settings into the cadence estimator with
// random idling on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_frame_cadence_bitrate_estimator_unit;
    import fcbe_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycles;
    bit                    calm;       // no idling at all while set
    logic [63:0]           stamp;      // running presentation time

    fcbe_in_if  in_ch ();
    fcbe_out_if out_ch ();

    frame_cadence_bitrate_estimator_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    fcbe_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_mon(in_ch), .out_mon(out_ch),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog: worst case per word plus stalls, many times over
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("tb_frame_cadence_bitrate_estimator_unit NOT OK");
            $finish;
        end
    end

    // receiver side holds ready low about 19 percent of the time except in calm stretches
    always @(negedge clk)
        out_ch.ready <= calm || ($urandom_range(99) >= 19);

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait until all estimates are back, then let the block settle
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // one buffer word; sender idles at random first
    task automatic send_word(input logic [1:0] cmd, input logic [63:0] ts,
                             input logic [31:0] bytes);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 19) @(negedge clk);
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.frame_time    <= ts;
        in_ch.payload_bytes <= bytes;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // mostly cadenced records with random gaps around the bucket edges
    task automatic random_word();
        int r;
        logic [63:0] gap;
        logic [31:0] bytes;
        r = $urandom_range(99);
        case ($urandom_range(7))
            0: gap = $urandom_range(3000000);
            1: gap = 64'd2000000 + $urandom_range(2) - 1;
            2: gap = 64'd40000000 + $urandom_range(2) - 1;
            3: gap = {$urandom, $urandom};
            default: gap = 64'd3000000 + $urandom_range(45000000);
        endcase
        bytes = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000);
        if ($urandom_range(19) == 0) bytes = 0;
        stamp = stamp + gap;
        if (r < 80)      send_word(CMD_RECORD, stamp, bytes);
        else if (r < 90) send_word(CMD_EVAL, {$urandom, $urandom}, $urandom);
        else if (r < 95) send_word(CMD_CLEAR, {$urandom, $urandom}, $urandom);
        else             send_word(2'd3, {$urandom, $urandom}, $urandom);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        calm = 0;
        stamp = 0;
        in_ch.valid = 0;
        in_ch.command = CMD_RECORD;
        in_ch.frame_time = '0;
        in_ch.payload_bytes = '0;
        out_ch.ready = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty history, extremes, zero payload, equal stamps, clear
        send_word(CMD_EVAL, 64'd0, 32'd0);
        send_word(CMD_RECORD, 64'd0, 32'hFFFF_FFFF);
        send_word(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_RECORD, 64'd100, 32'd0);
        send_word(CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
        send_word(2'd3, 64'd5, 32'd7);
        for (int i = 0; i < 10; i++)
            send_word(CMD_RECORD, 64'd1000 + i * 64'd3125000, 32'hFFFF_FFFF);
        send_word(CMD_CLEAR, 64'd0, 32'd0);
        send_word(CMD_RECORD, 64'd10, 32'd1);
        send_word(CMD_RECORD, 64'd1999999 + 10, 32'd1);
        drain();

        // encoder phases across register extremes
        reg_write(CFG_HIGH_PERF, 32'd1);
        reg_write(CFG_ENCODER_MODE, 32'd1);
        send_word(CMD_RECORD, 64'd1, 32'd5);
        drain();
        reg_write(CFG_FR_NUM, 32'hFFFF_FFFF);
        reg_write(CFG_FR_DEN, 32'd0);
        reg_write(CFG_RATE_CTRL, 32'd1);
        reg_write(CFG_BITRATE, 32'hFFFF_FFFF);
        send_word(CMD_EVAL, 64'd0, 32'd0);
        drain();
        reg_write(CFG_FR_DEN, 32'hFFFF_FFFF);
        reg_write(CFG_HIGH_PERF, 32'd0);
        send_word(CMD_RECORD, 64'd9, 32'd9);
        drain();
        reg_write(CFG_FR_NUM, 32'd0);
        send_word(CMD_EVAL, 64'd0, 32'd0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            reg_write(CFG_ENCODER_MODE, (ph % 4 == 3) ? 32'd1 : 32'd0);
            reg_write(CFG_HIGH_PERF, $urandom_range(1));
            reg_write(CFG_RATE_CTRL, $urandom_range(1));
            reg_write(CFG_FR_NUM, $urandom_range(1) ? $urandom : $urandom_range(1000));
            reg_write(CFG_FR_DEN, $urandom_range(4));
            reg_write(CFG_BITRATE, $urandom);
            calm = (ph == 2);
            for (int i = 0; i < 230; i++)
            begin
                random_word();
                if (i == 100) while (pending != 0) @(negedge clk);
            end
            calm = 0;
            drain();
        end

        drain();
        if (errors == 0)
            $display("tb_frame_cadence_bitrate_estimator_unit OK");
        else
            $display("tb_frame_cadence_bitrate_estimator_unit NOT OK");
        $finish;
    end

endmodule
